### hdl/bdlp_pkg.sv
// ----------------------------------------------------------------------------
// bdlp_pkg: shared types and constants for the button debouncer
// Register indexes, reset values and the result item layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bdlp_pkg;

    // Configuration port geometry
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESSED_LEVEL = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BOUNCE_TICKS  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_TICKS    = 2'd2;

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] BOUNCE_TICKS_RST = 16'd20;
    localparam logic [CFG_DATA_W-1:0] LONG_TICKS_RST   = 16'd1500;

    // One result item
    typedef struct packed {
        logic clicked;
        logic long_pressing;
        logic pressed_now;
        logic changed;
        logic release_event;
    } result_t;

endpackage

`default_nettype wire

### hdl/button_debounce_long_press.sv
// ----------------------------------------------------------------------------
// button_debounce_long_press: debouncer with click and long-press detection
// A result item is registered in the output register, or in the skid register while the output is held.
// Throughput: one item per cycle while the skid register is empty; the update of debounce state is one pass.
// A two-entry output (result register plus skid register) keeps input open
// while one result waits. Reset clears debounce state and valid flags and loads register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_long_press #(
    parameter int TIMER_WIDTH = 16
) (
    input  wire                                clk,
    input  wire                                rst_n,
    // configuration write port
    input  wire                                cfg_we,
    input  wire  [bdlp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire  [bdlp_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input channel
    input  wire                                in_valid,
    output logic                               in_stall,
    input  wire                                pin_level,
    input  wire                                clear_click,
    input  wire                                clear_change,
    // output channel
    output logic                               out_valid,
    input  wire                                out_stall,
    output logic                               clicked,
    output logic                               long_pressing,
    output logic                               pressed_now,
    output logic                               changed,
    output logic                               release_event
);

    import bdlp_pkg::*;

    localparam logic [TIMER_WIDTH-1:0] TIMER_ONE  = TIMER_WIDTH'(1);
    localparam logic [TIMER_WIDTH-1:0] TIMER_ZERO = '0;

    // Configuration registers
    logic                   pressed_level_reg;
    logic [CFG_DATA_W-1:0]  bounce_ticks_reg;
    logic [CFG_DATA_W-1:0]  long_ticks_reg;

    // Debounce state
    logic                   seeded_reg,        seeded_next;
    logic                   last_level_reg,    last_level_next;
    logic                   awaited_level_reg, awaited_level_next;
    logic                   bounce_active_reg, bounce_active_next;
    logic [TIMER_WIDTH-1:0] bounce_count_reg,  bounce_count_next;
    logic                   hold_active_reg,   hold_active_next;
    logic [TIMER_WIDTH-1:0] hold_count_reg,    hold_count_next;
    logic                   long_flag_reg,     long_flag_next;
    logic                   click_flag_reg,    click_flag_next;
    logic                   change_flag_reg,   change_flag_next;

    // Output staging
    logic                   out_valid_reg;
    logic                   skid_valid_reg;
    result_t                out_reg;
    result_t                skid_reg;
    result_t                result;

    logic                   accept;
    logic                   out_take;
    logic [TIMER_WIDTH-1:0] bounce_load;
    logic [TIMER_WIDTH-1:0] long_load;
    logic                   is_pressed;
    logic                   done;
    logic                   release_now;

    assign accept   = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;
    assign in_stall = skid_valid_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_level_reg <= 1'b0;
            bounce_ticks_reg  <= BOUNCE_TICKS_RST;
            long_ticks_reg    <= LONG_TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PRESSED_LEVEL: pressed_level_reg <= cfg_data[0];
                CFG_BOUNCE_TICKS:  bounce_ticks_reg  <= cfg_data;
                CFG_LONG_TICKS:    long_ticks_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Timer load values, saturated to the timer width
    generate
        if (TIMER_WIDTH >= CFG_DATA_W)
        begin : g_load_wide
            assign bounce_load = TIMER_WIDTH'(bounce_ticks_reg);
            assign long_load   = TIMER_WIDTH'(long_ticks_reg);
        end
        else
        begin : g_load_sat
            assign bounce_load = (|bounce_ticks_reg[CFG_DATA_W-1:TIMER_WIDTH]) ?
                                 {TIMER_WIDTH{1'b1}} : bounce_ticks_reg[TIMER_WIDTH-1:0];
            assign long_load   = (|long_ticks_reg[CFG_DATA_W-1:TIMER_WIDTH]) ?
                                 {TIMER_WIDTH{1'b1}} : long_ticks_reg[TIMER_WIDTH-1:0];
        end
    endgenerate

    assign is_pressed = (pin_level == pressed_level_reg);

    // Per-item state update
    always_comb
    begin
        seeded_next        = seeded_reg;
        last_level_next    = last_level_reg;
        awaited_level_next = awaited_level_reg;
        bounce_active_next = bounce_active_reg;
        bounce_count_next  = bounce_count_reg;
        hold_active_next   = hold_active_reg;
        hold_count_next    = hold_count_reg;
        long_flag_next     = long_flag_reg;
        click_flag_next    = click_flag_reg;
        change_flag_next   = change_flag_reg;
        release_now        = 1'b0;
        done               = 1'b0;

        if (!seeded_reg)
        begin
            // first sample only seeds the level
            seeded_next     = 1'b1;
            last_level_next = pin_level;
        end
        else
        begin
            // count down active timers
            if (bounce_active_reg && (bounce_count_reg != TIMER_ZERO))
                bounce_count_next = bounce_count_reg - TIMER_ONE;
            if (hold_active_reg && (hold_count_reg != TIMER_ZERO))
                hold_count_next = hold_count_reg - TIMER_ONE;

            // long press run-out
            if (hold_active_reg && (hold_count_next == TIMER_ZERO) && is_pressed)
            begin
                hold_active_next = 1'b0;
                long_flag_next   = 1'b1;
            end

            // bounce run-out
            if (bounce_active_reg && (bounce_count_next == TIMER_ZERO))
            begin
                bounce_active_next = 1'b0;
                if (pin_level != awaited_level_reg)
                    done = 1'b1;
                else
                begin
                    change_flag_next = 1'b1;
                    if (!is_pressed)
                    begin
                        last_level_next  = pin_level;
                        if (!long_flag_next)
                            click_flag_next = 1'b1;
                        long_flag_next   = 1'b0;
                        hold_active_next = 1'b0;
                        release_now      = 1'b1;
                        done             = 1'b1;
                    end
                end
            end

            // level change restarts the bounce timer
            if (!done && (pin_level != last_level_next))
            begin
                last_level_next = pin_level;
                if (!bounce_active_next)
                    awaited_level_next = pin_level;
                bounce_active_next = 1'b1;
                bounce_count_next  = bounce_load;
                if (is_pressed)
                begin
                    hold_active_next = 1'b1;
                    hold_count_next  = long_load;
                end
            end
        end

        result.clicked       = click_flag_next;
        result.long_pressing = long_flag_next;
        result.pressed_now   = is_pressed;
        result.changed       = change_flag_next;
        result.release_event = release_now;
    end

    // Commit state on each accepted item; clears act after the result is formed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seeded_reg        <= 1'b0;
            last_level_reg    <= 1'b0;
            awaited_level_reg <= 1'b0;
            bounce_active_reg <= 1'b0;
            bounce_count_reg  <= '0;
            hold_active_reg   <= 1'b0;
            hold_count_reg    <= '0;
            long_flag_reg     <= 1'b0;
            click_flag_reg    <= 1'b0;
            change_flag_reg   <= 1'b0;
        end
        else if (accept)
        begin
            seeded_reg        <= seeded_next;
            last_level_reg    <= last_level_next;
            awaited_level_reg <= awaited_level_next;
            bounce_active_reg <= bounce_active_next;
            bounce_count_reg  <= bounce_count_next;
            hold_active_reg   <= hold_active_next;
            hold_count_reg    <= hold_count_next;
            long_flag_reg     <= long_flag_next;
            click_flag_reg    <= click_flag_next && !clear_click;
            change_flag_reg   <= change_flag_next && !clear_change;
        end
    end

    // Output register and skid stage: valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= accept;
        end
        else if (accept)
            skid_valid_reg <= 1'b1;
    end

    // Output register and skid stage: payload
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (accept)
                out_reg <= result;
        end
        else if (accept)
            skid_reg <= result;
    end

    assign out_valid     = out_valid_reg;
    assign clicked       = out_reg.clicked;
    assign long_pressing = out_reg.long_pressing;
    assign pressed_now   = out_reg.pressed_now;
    assign changed       = out_reg.changed;
    assign release_event = out_reg.release_event;

    // A waiting skid item always sits behind a valid output item
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds an item while output register is empty");

    // An item that arrives while the output is held lands in the skid stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && out_valid_reg && out_stall) |=> skid_valid_reg)
        else $error("item lost while output was stalled");

    // A release always sets the changed flag in the same item
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.release_event) |-> out_reg.changed)
        else $error("release without changed flag");

    // No timer runs before the first sample has seeded the level
    assert property (@(posedge clk) disable iff (!rst_n)
        !seeded_reg |-> (!bounce_active_reg && !hold_active_reg))
        else $error("timer active before seeding");

endmodule

`default_nettype wire

### dv/button_debounce_long_press_tb.sv
// ----------------------------------------------------------------------------
// button_debounce_long_press_tb: self-checking bench for the button debouncer
// A queue of pin samples feeds a driver; a monitor predicts one result per
// accepted item and compares it field by field with what the block returns.
// Phases sweep the pressed level and both timers, down to zero and up to max.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_debounce_long_press_tb;

    import bdlp_pkg::*;

    // Index that maps to no register; writes there must be ignored
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    // Directed pin pattern, tick 0 on the left
    localparam logic [0:24] DIR_PIN       = 25'b0100011111000010110011110;
    localparam logic [0:24] DIR_CLR_CLICK = 25'b0000000000001000000100001;
    localparam logic [0:24] DIR_CLR_CHG   = 25'b0000000100000100000010001;

    typedef struct packed {
        logic pin;
        logic clr_click;
        logic clr_change;
    } sample_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;
    logic                   in_valid      = 1'b0;
    logic                   in_stall;
    logic                   pin_level     = 1'b0;
    logic                   clear_click   = 1'b0;
    logic                   clear_change  = 1'b0;
    logic                   out_valid;
    logic                   out_stall     = 1'b0;
    logic                   clicked;
    logic                   long_pressing;
    logic                   pressed_now;
    logic                   changed;
    logic                   release_event;

    sample_t samples_pending[$];
    result_t results_due[$];
    sample_t drive_item;
    result_t exp_result;
    logic    item_taken = 1'b0;
    logic    calm       = 1'b0;
    logic    failed     = 1'b0;
    int      gap_left   = 0;
    int      stall_left = 0;

    // Predictor copy of the registers
    logic        cfg_pressed;
    logic [15:0] cfg_bounce;
    logic [15:0] cfg_long;

    // Predictor copy of the debounce state
    logic        seeded;
    logic        last_level;
    logic        awaited;
    logic        bounce_on;
    logic [15:0] bounce_left;
    logic        hold_on;
    logic [15:0] hold_left;
    logic        long_flag;
    logic        click_flag;
    logic        change_flag;

    initial
    begin
        cfg_pressed = 1'b0;
        cfg_bounce  = BOUNCE_TICKS_RST;
        cfg_long    = LONG_TICKS_RST;
        seeded      = 1'b0;
        last_level  = 1'b0;
        awaited     = 1'b0;
        bounce_on   = 1'b0;
        bounce_left = '0;
        hold_on     = 1'b0;
        hold_left   = '0;
        long_flag   = 1'b0;
        click_flag  = 1'b0;
        change_flag = 1'b0;
    end

    button_debounce_long_press i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pin_level     (pin_level),
        .clear_click   (clear_click),
        .clear_change  (clear_change),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .clicked       (clicked),
        .long_pressing (long_pressing),
        .pressed_now   (pressed_now),
        .changed       (changed),
        .release_event (release_event)
    );

    always #5 clk = ~clk;

    // Advance the debounce state by one tick and return the result item
    function automatic result_t debounce_tick(logic pin, logic clr_click, logic clr_change);
        result_t r;
        logic    rel;
        logic    stop;
        rel  = 1'b0;
        stop = 1'b0;
        if (!seeded)
        begin
            seeded     = 1'b1;
            last_level = pin;
        end
        else
        begin
            if (bounce_on && bounce_left != 0)
                bounce_left = bounce_left - 1'b1;
            if (hold_on && hold_left != 0)
                hold_left = hold_left - 1'b1;
            if (hold_on && hold_left == 0 && pin == cfg_pressed)
            begin
                hold_on   = 1'b0;
                long_flag = 1'b1;
            end
            // bounce timer ran out: accept the level or drop the change
            if (bounce_on && bounce_left == 0)
            begin
                bounce_on = 1'b0;
                if (pin != awaited)
                    stop = 1'b1;
                else
                begin
                    change_flag = 1'b1;
                    if (pin != cfg_pressed)
                    begin
                        last_level = pin;
                        if (!long_flag)
                            click_flag = 1'b1;
                        long_flag = 1'b0;
                        hold_on   = 1'b0;
                        rel       = 1'b1;
                        stop      = 1'b1;
                    end
                end
            end
            // level change: restart the bounce timer, and the long timer on a press
            if (!stop && pin != last_level)
            begin
                last_level = pin;
                if (!bounce_on)
                    awaited = pin;
                bounce_on   = 1'b1;
                bounce_left = cfg_bounce;
                if (pin == cfg_pressed)
                begin
                    hold_on   = 1'b1;
                    hold_left = cfg_long;
                end
            end
        end
        r.clicked       = click_flag;
        r.long_pressing = long_flag;
        r.pressed_now   = (pin == cfg_pressed);
        r.changed       = change_flag;
        r.release_event = rel;
        if (clr_click)
            click_flag = 1'b0;
        if (clr_change)
            change_flag = 1'b0;
        return r;
    endfunction

    function automatic void check_field(string name, logic expected, logic actual);
        if (actual !== expected)
        begin
            $error("%s: expected %0b, got %0b", name, expected, actual);
            failed = 1'b1;
        end
    endfunction

    // Check returned items, predict accepted items, track register writes
    always @(posedge clk)
    begin
        item_taken <= rst_n && in_valid && !in_stall;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (results_due.size() == 0)
                begin
                    $error("result item returned with none expected");
                    failed = 1'b1;
                end
                else
                begin
                    exp_result = results_due.pop_front();
                    check_field("clicked", exp_result.clicked, clicked);
                    check_field("long_pressing", exp_result.long_pressing, long_pressing);
                    check_field("pressed_now", exp_result.pressed_now, pressed_now);
                    check_field("changed", exp_result.changed, changed);
                    check_field("release_event", exp_result.release_event, release_event);
                end
            end
            if (in_valid && !in_stall)
                results_due.push_back(debounce_tick(pin_level, clear_click, clear_change));
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PRESSED_LEVEL: cfg_pressed = cfg_data[0];
                    CFG_BOUNCE_TICKS:  cfg_bounce  = cfg_data;
                    CFG_LONG_TICKS:    cfg_long    = cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Drive the next item, with random idle bursts between items
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || item_taken)
        begin
            if (!calm && gap_left != 0)
            begin
                gap_left = gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 15) == 0)
            begin
                gap_left = $urandom_range(0, 16);
                in_valid <= 1'b0;
            end
            else if (samples_pending.size() != 0)
            begin
                drive_item = samples_pending.pop_front();
                in_valid     <= 1'b1;
                pin_level    <= drive_item.pin;
                clear_click  <= drive_item.clr_click;
                clear_change <= drive_item.clr_change;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Stall the result side in random bursts
    always @(negedge clk)
    begin
        if (!calm && stall_left != 0)
        begin
            stall_left = stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 11) == 0)
        begin
            stall_left = $urandom_range(0, 16);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic push_sample(logic pin);
        sample_t s;
        s.pin        = pin;
        s.clr_click  = ($urandom_range(0, 3) == 0);
        s.clr_change = ($urandom_range(0, 3) == 0);
        samples_pending.push_back(s);
    endtask

    // Queue button gestures: chatter, a held press, chatter, a rest; some noise
    task automatic queue_gestures(int n_items);
        int hold_max;
        int rest_max;
        int run;
        hold_max = cfg_bounce + cfg_long + 4;
        rest_max = 2 * cfg_bounce + 4;
        if (hold_max > 80)
            hold_max = 80;
        if (rest_max > 80)
            rest_max = 80;
        while (samples_pending.size() < n_items)
        begin
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 6)) push_sample(1'($urandom_range(0, 1)));
            else
            begin
                repeat ($urandom_range(0, 3)) push_sample(1'($urandom_range(0, 1)));
                run = $urandom_range(1, hold_max);
                repeat (run) push_sample(cfg_pressed);
                repeat ($urandom_range(0, 3)) push_sample(1'($urandom_range(0, 1)));
                run = $urandom_range(1, rest_max);
                repeat (run) push_sample(~cfg_pressed);
            end
        end
    endtask

    // Hold until every item is taken and every result has come back
    task automatic wait_idle();
        while (samples_pending.size() != 0 || in_valid || results_due.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(logic pressed, logic [15:0] bounce, logic [15:0] hold,
                             int n_items);
        wait_idle();
        write_reg(CFG_PRESSED_LEVEL, {15'd0, pressed});
        write_reg(CFG_BOUNCE_TICKS, bounce);
        write_reg(CFG_LONG_TICKS, hold);
        @(posedge clk);
        queue_gestures(n_items);
    endtask

    // Main sequence
    initial
    begin
        sample_t s;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // directed: seeding, a dropped glitch, click, long press, clears
        write_reg(CFG_PRESSED_LEVEL, 16'd1);
        write_reg(CFG_BOUNCE_TICKS, 16'd1);
        write_reg(CFG_LONG_TICKS, 16'd3);
        @(posedge clk);
        for (int i = 0; i < 25; i++)
        begin
            s.pin        = DIR_PIN[i];
            s.clr_click  = DIR_CLR_CLICK[i];
            s.clr_change = DIR_CLR_CHG[i];
            samples_pending.push_back(s);
        end

        // register defaults, zero timers, maximum timers, then mid values
        run_phase(1'b0, BOUNCE_TICKS_RST, LONG_TICKS_RST, 200);
        run_phase(1'b1, 16'd0, 16'd0, 200);
        run_phase(1'b0, 16'hFFFF, 16'hFFFF, 30);
        wait_idle();
        write_reg(CFG_UNUSED, 16'hFFFF);
        run_phase(1'b1, 16'd3, 16'd12, 350);

        // last stretch runs without idling on either side
        wait_idle();
        calm = 1'b1;
        run_phase(1'b0, 16'd2, 16'd8, 350);

        wait_idle();
        repeat (5) @(posedge clk);
        if (!failed)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Timeout
    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
